// ===== rtl/ght_pkg.sv =====
`timescale 1ns / 1ps

package ght_pkg;

    // Field widths of the request and result items
    localparam int IDX_IN_W   = 6;
    localparam int GEN_IN_W   = 16;

    // Slots examined by the search unit in one cycle
    localparam int SCAN_CHUNK = 8;

    typedef enum logic [1:0] {
        MODE_CREATE  = 2'd0,
        MODE_DESTROY = 2'd1,
        MODE_LOOKUP  = 2'd2,
        MODE_ITERATE = 2'd3
    } t_mode;

    typedef enum logic [1:0] {
        ST_OK    = 2'd0,
        ST_FULL  = 2'd1,
        ST_STALE = 2'd2,
        ST_END   = 2'd3
    } t_status;

    typedef struct packed {
        t_mode                 mode;
        logic [IDX_IN_W-1:0]   handle_index;
        logic [GEN_IN_W-1:0]   handle_generation;
    } t_req;

    typedef struct packed {
        t_status               status;
        logic [IDX_IN_W-1:0]   result_index;
        logic [GEN_IN_W-1:0]   result_generation;
    } t_rsp;

endpackage

// ===== rtl/ght_gen_ram.sv =====
`timescale 1ns / 1ps

module ght_gen_ram #(
    parameter int DEPTH  = 64,
    parameter int ADDR_W = 6,
    parameter int DATA_W = 16
) (
    input  logic              i_clk,
    input  logic              i_we,
    input  logic [ADDR_W-1:0] i_waddr,
    input  logic [DATA_W-1:0] i_wdata,
    input  logic [ADDR_W-1:0] i_raddr,
    output logic [DATA_W-1:0] o_rdata
);

    logic [DATA_W-1:0] r_mem [DEPTH];

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        o_rdata <= r_mem[i_raddr];
    end

endmodule

// ===== rtl/ght_scan.sv =====
`timescale 1ns / 1ps

module ght_scan import ght_pkg::*; #(
    parameter int SLOT_COUNT = 64,
    parameter int IDX_W      = 6
) (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_start,
    input  logic                  i_want,
    input  logic [IDX_W-1:0]      i_from,
    input  logic [SLOT_COUNT-1:0] i_used,
    output logic                  o_done,
    output logic                  o_found,
    output logic [IDX_W-1:0]      o_index
);

    localparam int CHUNK_W = $clog2(SCAN_CHUNK);
    localparam int NCHUNK  = (SLOT_COUNT + SCAN_CHUNK - 1) / SCAN_CHUNK;
    localparam int CH_W    = (NCHUNK > 1) ? $clog2(NCHUNK) : 1;
    localparam int PAD_N   = NCHUNK * SCAN_CHUNK;
    localparam int PAD_W   = $clog2(PAD_N);

    logic                  r_busy;
    logic                  r_want;
    logic [CH_W-1:0]       r_chunk;
    logic [CHUNK_W-1:0]    r_low;

    logic [PAD_W-1:0]      w_from_pad;
    logic [PAD_N-1:0]      w_used_pad;
    logic [PAD_N-1:0]      w_slot_pad;
    logic [SCAN_CHUNK-1:0] w_word;
    logic [SCAN_CHUNK-1:0] w_real;
    logic [SCAN_CHUNK-1:0] w_cand;
    logic [CHUNK_W-1:0]    w_pos;
    logic                  w_any;
    logic                  w_last;
    logic [PAD_W-1:0]      w_hit;

    assign w_from_pad = PAD_W'(i_from);
    assign w_used_pad = PAD_N'(i_used);
    assign w_slot_pad = PAD_N'({SLOT_COUNT{1'b1}});
    assign w_word     = w_used_pad[r_chunk*SCAN_CHUNK +: SCAN_CHUNK];
    assign w_real     = w_slot_pad[r_chunk*SCAN_CHUNK +: SCAN_CHUNK];
    assign w_last     = (r_chunk == CH_W'(NCHUNK - 1));

    always_comb begin
        for (int k = 0; k < SCAN_CHUNK; k++) begin
            w_cand[k] = (r_want ? w_word[k] : !w_word[k]) && w_real[k]
                        && (CHUNK_W'(k) >= r_low);
        end
        // lowest candidate wins
        w_pos = '0;
        for (int k = SCAN_CHUNK - 1; k >= 0; k--) begin
            if (w_cand[k]) begin
                w_pos = CHUNK_W'(k);
            end
        end
        w_any = |w_cand;
        w_hit = (PAD_W'(r_chunk) << CHUNK_W) | PAD_W'(w_pos);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            o_done <= 1'b0;
        end else begin
            o_done <= 1'b0;
            if (i_start) begin
                r_busy  <= 1'b1;
                r_want  <= i_want;
                r_chunk <= CH_W'(w_from_pad >> CHUNK_W);
                r_low   <= w_from_pad[CHUNK_W-1:0];
            end else if (r_busy) begin
                if (w_any) begin
                    o_done  <= 1'b1;
                    o_found <= 1'b1;
                    o_index <= IDX_W'(w_hit);
                    r_busy  <= 1'b0;
                end else if (w_last) begin
                    o_done  <= 1'b1;
                    o_found <= 1'b0;
                    r_busy  <= 1'b0;
                end else begin
                    // advance to next aligned chunk, full width
                    r_chunk <= r_chunk + CH_W'(1);
                    r_low   <= '0;
                end
            end
        end
    end

endmodule

// ===== rtl/generational_handle_table_core.sv =====
`timescale 1ns / 1ps
// Destroy and lookup pass from accept through S_READ and S_EVAL to the result. Create and
// iterate first wait in S_SCAN while the search unit walks 8-slot chunks, then go through
// S_READ and S_EVAL with a slot found, or strobe from S_SCAN with none. A null or out-of-range
// handle, or an iterate starting past the table, answers on accept; busy drops in the cycle
// the result is strobed. Reset: a clearing pass writes zero to every generation, busy high.
// The receiver cannot stall; each result is shown for exactly one cycle.

module generational_handle_table_core import ght_pkg::*; #(
    parameter int SLOT_COUNT      = 64,
    parameter int GENERATION_BITS = 16
) (
    input  logic i_clk,
    input  logic i_rst_n,
    input  logic start,
    output logic busy,
    input  t_req i_req,
    output logic o_valid,
    output t_rsp o_rsp
);

    localparam int IDX_W     = (SLOT_COUNT > 1) ? $clog2(SLOT_COUNT) : 1;
    localparam int CMP_W     = ((IDX_W > IDX_IN_W) ? IDX_W : IDX_IN_W) + 1;
    localparam int GEN_CMP_W = (GENERATION_BITS > GEN_IN_W) ? GENERATION_BITS : GEN_IN_W;

    typedef enum logic [2:0] {
        S_CLEAR,
        S_IDLE,
        S_SCAN,
        S_READ,
        S_EVAL
    } t_state;

    t_state                     r_state;
    t_mode                      r_mode;
    logic [GEN_IN_W-1:0]        r_hgen;
    logic [IDX_W-1:0]           r_slot;
    logic [IDX_W-1:0]           r_clr;
    logic [SLOT_COUNT-1:0]      r_used;

    logic                       w_accept;
    logic [CMP_W-1:0]           w_idx_ext;
    logic [CMP_W-1:0]           w_it_start;
    logic                       w_it_ok;
    logic                       w_idx_ok;
    logic                       w_scan_start;
    logic                       w_scan_want;
    logic [IDX_W-1:0]           w_scan_from;
    logic                       w_scan_done;
    logic                       w_scan_found;
    logic [IDX_W-1:0]           w_scan_index;
    logic                       w_we;
    logic [IDX_W-1:0]           w_waddr;
    logic [GENERATION_BITS-1:0] w_wdata;
    logic [GENERATION_BITS-1:0] w_rdata;
    logic [GENERATION_BITS-1:0] w_gen_next;
    logic                       w_live;
    logic [CMP_W-1:0]           w_slot_ext;
    logic [GEN_CMP_W-1:0]       w_rdata_ext;
    logic [GEN_CMP_W-1:0]       w_next_ext;

    assign busy       = (r_state != S_IDLE);
    assign w_accept   = start && (r_state == S_IDLE);
    assign w_idx_ext  = CMP_W'(i_req.handle_index);
    assign w_idx_ok   = (w_idx_ext < CMP_W'(SLOT_COUNT));
    assign w_it_start = (i_req.handle_generation == '0) ? '0 : w_idx_ext + CMP_W'(1);
    assign w_it_ok    = (w_it_start < CMP_W'(SLOT_COUNT));

    assign w_scan_start = w_accept && ((i_req.mode == MODE_CREATE)
                          || ((i_req.mode == MODE_ITERATE) && w_it_ok));
    assign w_scan_want  = (i_req.mode == MODE_ITERATE);
    assign w_scan_from  = (i_req.mode == MODE_CREATE) ? '0 : IDX_W'(w_it_start);

    // wrap from all ones back to one, never to the null generation
    assign w_gen_next = (w_rdata == '1) ? GENERATION_BITS'(1)
                                        : w_rdata + GENERATION_BITS'(1);
    assign w_live     = r_used[r_slot] && (r_hgen != '0)
                        && (GEN_CMP_W'(w_rdata) == GEN_CMP_W'(r_hgen));

    assign w_slot_ext  = CMP_W'(r_slot);
    assign w_rdata_ext = GEN_CMP_W'(w_rdata);
    assign w_next_ext  = GEN_CMP_W'(w_gen_next);

    assign w_we    = (r_state == S_CLEAR) || ((r_state == S_EVAL) && (r_mode == MODE_CREATE));
    assign w_waddr = (r_state == S_CLEAR) ? r_clr : r_slot;
    assign w_wdata = (r_state == S_CLEAR) ? '0 : w_gen_next;

    ght_scan #(
        .SLOT_COUNT (SLOT_COUNT),
        .IDX_W      (IDX_W)
    ) u_scan (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (w_scan_start),
        .i_want  (w_scan_want),
        .i_from  (w_scan_from),
        .i_used  (r_used),
        .o_done  (w_scan_done),
        .o_found (w_scan_found),
        .o_index (w_scan_index)
    );

    ght_gen_ram #(
        .DEPTH  (SLOT_COUNT),
        .ADDR_W (IDX_W),
        .DATA_W (GENERATION_BITS)
    ) u_gen_ram (
        .i_clk   (i_clk),
        .i_we    (w_we),
        .i_waddr (w_waddr),
        .i_wdata (w_wdata),
        .i_raddr (r_slot),
        .o_rdata (w_rdata)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_CLEAR;
            r_clr   <= '0;
            r_used  <= '0;
            o_valid <= 1'b0;
        end else begin
            o_valid <= 1'b0;
            case (r_state)
                S_CLEAR: begin
                    r_clr <= r_clr + IDX_W'(1);
                    if (r_clr == IDX_W'(SLOT_COUNT - 1)) begin
                        r_state <= S_IDLE;
                    end
                end
                S_IDLE: begin
                    if (start) begin
                        r_mode <= i_req.mode;
                        r_hgen <= i_req.handle_generation;
                        case (i_req.mode)
                            MODE_CREATE: begin
                                r_state <= S_SCAN;
                            end
                            MODE_ITERATE: begin
                                if (w_it_ok) begin
                                    r_state <= S_SCAN;
                                end else begin
                                    o_valid <= 1'b1;
                                    o_rsp   <= '{ST_END, '0, '0};
                                end
                            end
                            default: begin
                                if (w_idx_ok && (i_req.handle_generation != '0)) begin
                                    r_slot  <= IDX_W'(w_idx_ext);
                                    r_state <= S_READ;
                                end else begin
                                    o_valid <= 1'b1;
                                    o_rsp   <= '{ST_STALE, '0, '0};
                                end
                            end
                        endcase
                    end
                end
                S_SCAN: begin
                    if (w_scan_done) begin
                        if (w_scan_found) begin
                            r_slot  <= w_scan_index;
                            r_state <= S_READ;
                        end else begin
                            o_valid <= 1'b1;
                            o_rsp   <= '{(r_mode == MODE_CREATE) ? ST_FULL : ST_END, '0, '0};
                            r_state <= S_IDLE;
                        end
                    end
                end
                S_READ: begin
                    r_state <= S_EVAL;
                end
                S_EVAL: begin
                    o_valid <= 1'b1;
                    r_state <= S_IDLE;
                    case (r_mode)
                        MODE_CREATE: begin
                            r_used[r_slot] <= 1'b1;
                            o_rsp <= '{ST_OK, w_slot_ext[IDX_IN_W-1:0],
                                       w_next_ext[GEN_IN_W-1:0]};
                        end
                        MODE_ITERATE: begin
                            o_rsp <= '{ST_OK, w_slot_ext[IDX_IN_W-1:0],
                                       w_rdata_ext[GEN_IN_W-1:0]};
                        end
                        default: begin
                            if (w_live) begin
                                if (r_mode == MODE_DESTROY) begin
                                    r_used[r_slot] <= 1'b0;
                                end
                                o_rsp <= '{ST_OK, w_slot_ext[IDX_IN_W-1:0], r_hgen};
                            end else begin
                                o_rsp <= '{ST_STALE, '0, '0};
                            end
                        end
                    endcase
                end
                default: begin
                    r_state <= S_IDLE;
                end
            endcase
        end
    end

endmodule

// ===== rtl/ght_checker.sv =====
`timescale 1ns / 1ps

module ght_checker import ght_pkg::*; (
    input logic i_clk,
    input logic i_rst_n,
    input logic start,
    input logic busy,
    input logic o_valid,
    input t_rsp o_rsp
);

    // reset starts the clearing pass and drops any pending result
    a_reset_quiet: assert property (@(posedge i_clk)
        !i_rst_n |=> !o_valid && busy)
        else $error("result strobe or idle right after reset");

    // failed requests carry no handle
    a_zero_fields: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && (o_rsp.status != ST_OK)
        |-> (o_rsp.result_index == '0) && (o_rsp.result_generation == '0))
        else $error("non-ok result with nonzero fields");

    // a result only follows work in progress or a fresh request
    a_result_cause: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |-> $past(busy || start))
        else $error("result without a request");

    // back-to-back results need a request accepted on the first one
    a_back_to_back: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && $past(o_valid) |-> $past(start))
        else $error("repeated result strobe");

endmodule

bind generational_handle_table_core ght_checker u_ght_checker (.*);

// ===== bench/tb_generational_handle_table_core.sv =====
`timescale 1ns / 1ps

module tb_generational_handle_table_core;
    import ght_pkg::*;

    localparam int SLOTS         = 64;
    localparam int LIMIT_CYCLES  = 200000;
    localparam int SETTLE_CYCLES = 24;
    localparam int RANDOM_ITEMS  = 850;
    localparam int TARGET_SPAN   = 120;

    class handle_table_scoreboard;
        bit        slot_used [SLOTS];
        bit [15:0] slot_gen  [SLOTS];
        t_rsp      pending_rsp [$];
        int        errors;
        int        accepted;
        int        peak_live;
        int        status_count [4];

        function bit handle_live(bit [5:0] idx, bit [15:0] gen);
            return gen != 16'd0 && slot_used[idx] && slot_gen[idx] == gen;
        endfunction

        function int live_count();
            int cnt;
            cnt = 0;
            foreach (slot_used[i]) cnt += slot_used[i];
            return cnt;
        endfunction

        function int pick_live();
            int k;
            int seen;
            k = live_count();
            if (k == 0) return -1;
            k = $urandom_range(k - 1);
            seen = 0;
            foreach (slot_used[i]) begin
                if (slot_used[i]) begin
                    if (seen == k) return i;
                    seen++;
                end
            end
            return -1;
        endfunction

        // Apply one accepted request to the table and queue the reply it must give.
        function void note_request(t_req req);
            t_rsp rsp;
            int   scan;
            rsp = '0;
            case (req.mode)
                MODE_CREATE: begin
                    rsp.status = ST_FULL;
                    for (scan = 0; scan < SLOTS; scan++) begin
                        if (!slot_used[scan]) begin
                            slot_gen[scan] = (slot_gen[scan] == 16'hFFFF) ? 16'd1
                                                                          : slot_gen[scan] + 16'd1;
                            slot_used[scan]       = 1'b1;
                            rsp.status            = ST_OK;
                            rsp.result_index      = scan[5:0];
                            rsp.result_generation = slot_gen[scan];
                            break;
                        end
                    end
                end
                MODE_DESTROY, MODE_LOOKUP: begin
                    rsp.status = ST_STALE;
                    if (handle_live(req.handle_index, req.handle_generation)) begin
                        if (req.mode == MODE_DESTROY) slot_used[req.handle_index] = 1'b0;
                        rsp.status            = ST_OK;
                        rsp.result_index      = req.handle_index;
                        rsp.result_generation = req.handle_generation;
                    end
                end
                default: begin
                    // Scan upward: from slot 0 for a null handle, else past the given slot.
                    scan = (req.handle_generation == 16'd0) ? 0 : int'(req.handle_index) + 1;
                    rsp.status = ST_END;
                    while (scan < SLOTS) begin
                        if (slot_used[scan]) begin
                            rsp.status            = ST_OK;
                            rsp.result_index      = scan[5:0];
                            rsp.result_generation = slot_gen[scan];
                            break;
                        end
                        scan++;
                    end
                end
            endcase
            accepted++;
            if (live_count() > peak_live) peak_live = live_count();
            pending_rsp.push_back(rsp);
        endfunction

        function void check_result(t_rsp got);
            t_rsp want;
            if (pending_rsp.size() == 0) begin
                $error("unexpected result: status %0d index %0d generation %0d",
                       got.status, got.result_index, got.result_generation);
                errors++;
                return;
            end
            want = pending_rsp.pop_front();
            status_count[want.status]++;
            if (got.status !== want.status) begin
                $error("status: expected %0d, got %0d", want.status, got.status);
                errors++;
            end
            if (got.result_index !== want.result_index) begin
                $error("result_index: expected %0d, got %0d",
                       want.result_index, got.result_index);
                errors++;
            end
            if (got.result_generation !== want.result_generation) begin
                $error("result_generation: expected %0d, got %0d",
                       want.result_generation, got.result_generation);
                errors++;
            end
        endfunction
    endclass

    logic i_clk;
    logic i_rst_n;
    logic start;
    logic busy;
    t_req i_req;
    logic o_valid;
    t_rsp o_rsp;

    handle_table_scoreboard table_sb = new;
    int idle_pct;
    int occ_target;
    int cycles;

    generational_handle_table_core #(
        .SLOT_COUNT      (SLOTS),
        .GENERATION_BITS (16)
    ) DUT (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .start   (start),
        .busy    (busy),
        .i_req   (i_req),
        .o_valid (o_valid),
        .o_rsp   (o_rsp)
    );

    initial begin
        i_clk = 1'b0;
        forever #6 i_clk = ~i_clk;
    end

    initial begin
        cycles = 0;
        while (cycles < LIMIT_CYCLES) begin
            @(posedge i_clk);
            cycles++;
        end
        $display("timeout after %0d cycles", cycles);
        $display("tb_generational_handle_table_core failed");
        $finish;
    end

    always @(posedge i_clk) begin
        if (i_rst_n === 1'b1) begin
            if (o_valid === 1'b1) begin
                table_sb.check_result(o_rsp);
            end else if (o_valid !== 1'b0) begin
                $error("o_valid unknown");
                table_sb.errors++;
            end
        end
    end

    function automatic t_req make_req(t_mode mode, int idx, int gen);
        t_req r;
        r.mode              = mode;
        r.handle_index      = 6'(idx);
        r.handle_generation = 16'(gen);
        return r;
    endfunction

    // Hold start until the block takes the item, then maybe drop it for a while.
    task automatic send_request(t_req req);
        start <= 1'b1;
        i_req <= req;
        do @(posedge i_clk); while (busy !== 1'b0);
        table_sb.note_request(req);
        if ($urandom_range(99) < idle_pct) begin
            start <= 1'b0;
            i_req <= make_req(t_mode'($urandom_range(3)), $urandom_range(63),
                              $urandom_range(65535));
            repeat ($urandom_range(1, 14)) @(posedge i_clk);
        end
    endtask

    // Mostly well-formed traffic steered toward an occupancy target, plus stale
    // handles and raw noise.
    function automatic t_req pick_request();
        t_req r;
        int   roll;
        int   slot;
        r    = make_req(t_mode'($urandom_range(3)), $urandom_range(63), $urandom_range(65535));
        roll = $urandom_range(99);
        slot = table_sb.pick_live();
        if (roll < 45) begin
            if (table_sb.live_count() < occ_target || slot < 0) begin
                r.mode = MODE_CREATE;
            end else begin
                r = make_req(MODE_DESTROY, slot, table_sb.slot_gen[slot]);
            end
        end else if (roll < 60) begin
            if (slot < 0) r.mode = MODE_CREATE;
            else r = make_req(MODE_LOOKUP, slot, table_sb.slot_gen[slot]);
        end else if (roll < 75) begin
            r.mode = MODE_ITERATE;
            if ($urandom_range(1) == 0) r.handle_generation = '0;
            else if (slot >= 0) r = make_req(MODE_ITERATE, slot, table_sb.slot_gen[slot]);
        end else if (roll < 87) begin
            r.mode = $urandom_range(1) ? MODE_DESTROY : MODE_LOOKUP;
            r.handle_generation = table_sb.slot_gen[r.handle_index];
            if (table_sb.slot_used[r.handle_index])
                r.handle_generation += 16'($urandom_range(1, 3));
        end
        return r;
    endfunction

    initial begin
        i_rst_n   = 1'b0;
        start     = 1'b0;
        i_req     = '0;
        idle_pct  = 30;
        occ_target = SLOTS;
        repeat (4) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        send_request(make_req(MODE_LOOKUP, 5, 0));
        send_request(make_req(MODE_ITERATE, 0, 0));
        send_request(make_req(MODE_DESTROY, 63, 16'hFFFF));
        repeat (3) send_request(make_req(MODE_CREATE, 0, 0));
        send_request(make_req(MODE_LOOKUP, 0, 1));
        send_request(make_req(MODE_LOOKUP, 1, 2));
        send_request(make_req(MODE_ITERATE, 0, 0));
        send_request(make_req(MODE_ITERATE, 0, 5));
        send_request(make_req(MODE_ITERATE, 2, 1));
        send_request(make_req(MODE_ITERATE, 63, 16'hFFFF));
        send_request(make_req(MODE_DESTROY, 1, 1));
        send_request(make_req(MODE_DESTROY, 1, 1));
        send_request(make_req(MODE_LOOKUP, 1, 1));
        send_request(make_req(MODE_ITERATE, 0, 1));
        send_request(make_req(MODE_CREATE, 63, 16'hFFFF));
        send_request(make_req(MODE_LOOKUP, 1, 2));
        send_request(make_req(MODE_DESTROY, 2, 0));
        send_request(make_req(MODE_DESTROY, 0, 16'hAAAA));
        send_request(make_req(MODE_LOOKUP, 42, 16'h5555));
        send_request(make_req(MODE_ITERATE, 62, 1));

        for (int n = 0; n < RANDOM_ITEMS; n++) begin
            if (n == RANDOM_ITEMS / 3) idle_pct = 72;
            if (n == 2 * RANDOM_ITEMS / 3) idle_pct = 0;
            if (n % TARGET_SPAN == 0) begin
                case ($urandom_range(3))
                    0: occ_target = SLOTS;
                    1: occ_target = 0;
                    2: occ_target = $urandom_range(1, 8);
                    default: occ_target = $urandom_range(9, SLOTS - 1);
                endcase
            end
            send_request(pick_request());
        end
        start <= 1'b0;

        while (table_sb.pending_rsp.size() != 0) @(posedge i_clk);
        repeat (SETTLE_CYCLES) @(posedge i_clk);

        $display("%0d requests checked: %0d ok, %0d full, %0d stale or null, %0d end of scan",
                 table_sb.accepted, table_sb.status_count[ST_OK],
                 table_sb.status_count[ST_FULL], table_sb.status_count[ST_STALE],
                 table_sb.status_count[ST_END]);
        $display("peak occupancy %0d of %0d slots, %0d mismatches",
                 table_sb.peak_live, SLOTS, table_sb.errors);
        if (table_sb.errors == 0) begin
            $display("tb_generational_handle_table_core passed");
        end else begin
            $display("tb_generational_handle_table_core failed");
        end
        $finish;
    end

endmodule
